// File: sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spsc_pkg.sv
// Shared types and defaults for the strict-priority call scheduler.
// No dependencies; imported by every scheduler module.
`default_nettype none

package spsc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CLASSES_DEF = 4;

    typedef enum logic {
        KIND_ARRIVAL = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  job_class;
        logic [15:0] job_id;
        logic [15:0] job_length;
    } in_item_t;

    typedef struct packed {
        logic        started;
        logic [15:0] started_id;
        logic [1:0]  started_class;
        logic        busy_res;
        logic        all_empty;
        logic        dropped;
    } out_item_t;

    // One queue slot: length in the upper half, tag in the lower half.
    typedef struct packed {
        logic [15:0] job_length;
        logic [15:0] job_id;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/spsc_queue_mem.sv
// Job storage for all class queues: one write port, one registered read port.
// Read-during-write to the same slot returns the new entry. Uses spsc_pkg.
`default_nettype none

module spsc_queue_mem
    import spsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF * NUM_CLASSES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire entry_t                   wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/spsc_ctrl.sv
// Queue pointers, service state and per-item decision logic of the scheduler.
// Also picks the head slot to prefetch for the next item. Uses spsc_pkg.
`default_nettype none
`include "assert_macros.svh"

module spsc_ctrl
    import spsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        commit,
    input  wire in_item_t                                    item,
    input  wire entry_t                                      head_data,
    output logic                                             wr_en,
    output logic [$clog2(NUM_CLASSES*QUEUE_DEPTH)-1:0]       wr_addr,
    output entry_t                                           wr_data,
    output logic [$clog2(NUM_CLASSES*QUEUE_DEPTH)-1:0]       rd_addr,
    output out_item_t                                        result
);

    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_W     = $clog2(NUM_CLASSES);

    logic [PTR_W-1:0] heads_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] tails_reg  [NUM_CLASSES];
    logic [CNT_W-1:0] counts_reg [NUM_CLASSES];
    logic             in_service_reg;
    logic [CLS_W-1:0] serving_class_reg;
    logic [15:0]      remaining_reg;

    logic [PTR_W-1:0] heads_next  [NUM_CLASSES];
    logic [PTR_W-1:0] tails_next  [NUM_CLASSES];
    logic [CNT_W-1:0] counts_next [NUM_CLASSES];
    logic             in_service_next;
    logic [CLS_W-1:0] serving_class_next;
    logic [15:0]      remaining_next;

    logic [CLS_W-1:0] arr_cls;
    logic             arr_ok;
    logic             sel_found;
    logic [CLS_W-1:0] sel_cls;
    logic             pop_en;
    logic [CLS_W-1:0] pop_cls;
    logic [15:0]      need;
    logic [15:0]      rem_dec;
    logic [CLS_W-1:0] pf_cls;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign arr_cls = CLS_W'(item.job_class);
    assign arr_ok  = (int'(item.job_class) < NUM_CLASSES)
                     && (counts_reg[arr_cls] != CNT_W'(QUEUE_DEPTH));

    // Highest non-empty class for the current item.
    always_comb begin
        sel_found = 1'b0;
        sel_cls   = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (counts_reg[c] != '0) begin
                sel_found = 1'b1;
                sel_cls   = CLS_W'(c);
            end
        end
    end

    always_comb begin
        heads_next         = heads_reg;
        tails_next         = tails_reg;
        counts_next        = counts_reg;
        in_service_next    = in_service_reg;
        serving_class_next = serving_class_reg;
        remaining_next     = remaining_reg;
        wr_en              = 1'b0;
        wr_addr            = '0;
        wr_data            = '{job_length: item.job_length, job_id: item.job_id};
        result             = '0;
        pop_en             = 1'b0;
        pop_cls            = '0;
        need               = '0;
        rem_dec            = '0;

        if (item.kind == KIND_ARRIVAL) begin
            if (arr_ok) begin
                wr_en               = commit;
                wr_addr             = ADDR_W'(arr_cls) * ADDR_W'(QUEUE_DEPTH)
                                      + ADDR_W'(tails_reg[arr_cls]);
                tails_next[arr_cls]  = next_slot(tails_reg[arr_cls]);
                counts_next[arr_cls] = counts_reg[arr_cls] + CNT_W'(1);
            end else begin
                result.dropped = 1'b1;
            end
        end else if (in_service_reg) begin
            rem_dec        = (remaining_reg != '0) ? remaining_reg - 16'd1 : remaining_reg;
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
                pop_en          = 1'b1;
                pop_cls         = serving_class_reg;
                in_service_next = 1'b0;
            end
        end else if (sel_found) begin
            // head_data was prefetched from the head of sel_cls
            need                 = (head_data.job_length == '0) ? 16'd1 : head_data.job_length;
            result.started       = 1'b1;
            result.started_id    = head_data.job_id;
            result.started_class = 2'(sel_cls);
            if (need > 16'd1) begin
                remaining_next     = need - 16'd1;
                serving_class_next = sel_cls;
                in_service_next    = 1'b1;
            end else begin
                remaining_next = '0;
                pop_en         = 1'b1;
                pop_cls        = sel_cls;
            end
        end

        if (pop_en && (counts_reg[pop_cls] != '0)) begin
            heads_next[pop_cls]  = next_slot(heads_reg[pop_cls]);
            counts_next[pop_cls] = counts_reg[pop_cls] - CNT_W'(1);
        end

        result.busy_res  = in_service_next;
        result.all_empty = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (counts_next[c] != '0) begin
                result.all_empty = 1'b0;
            end
        end
    end

    // Prefetch address: head of the highest non-empty class as seen after this edge.
    always_comb begin
        pf_cls = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if ((commit ? counts_next[c] : counts_reg[c]) != '0) begin
                pf_cls = CLS_W'(c);
            end
        end
        rd_addr = ADDR_W'(pf_cls) * ADDR_W'(QUEUE_DEPTH)
                  + ADDR_W'(commit ? heads_next[pf_cls] : heads_reg[pf_cls]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                heads_reg[c]  <= '0;
                tails_reg[c]  <= '0;
                counts_reg[c] <= '0;
            end
            in_service_reg    <= 1'b0;
            serving_class_reg <= '0;
            remaining_reg     <= '0;
        end else if (commit) begin
            heads_reg         <= heads_next;
            tails_reg         <= tails_next;
            counts_reg        <= counts_next;
            in_service_reg    <= in_service_next;
            serving_class_reg <= serving_class_next;
            remaining_reg     <= remaining_next;
        end
    end

    // job in service still sits at the head of its queue
    `ASSERT_NOW(a_serving_queued, in_service_reg, counts_reg[serving_class_reg] != '0, "serving class queue empty")
    `ASSERT_NOW(a_serving_left, in_service_reg, remaining_reg != '0, "in service with no ticks left")
    `ASSERT_NEXT(a_start_only_tick, !in_service_reg && !(commit && result.started), !in_service_reg, "service began without a start")

endmodule

`default_nettype wire

// File: sv/strict_priority_call_scheduler.sv
// Strict-priority, non-preemptive call scheduler with per-class job FIFOs.
// Input channel s_*: one transaction per item, either a job arrival (class, tag,
//   length) or a service tick. Result channel m_*: exactly one transaction per
//   input item, in order, carrying start info, busy/empty status and drop flag.
// Pipeline: an accepted item is decided in the stage register and its result
//   lands in the output register, which drives m_valid; with m_ready high the
//   result transaction then completes.
// Throughput: one item per cycle while m_ready is high. The queue memory read for
//   the next item's head is issued on accept, addressed from the state the current
//   item leaves, so back-to-back ticks and arrivals run without bubbles.
// Reset (aresetn low, synchronous): pointers, counts and service state clear,
//   both channels go empty. Queue memory contents are not cleared; a slot is
//   only used after it has been written.
// Receiver stall: while m_ready is low the result holds in the output register;
//   the decision stage then holds too and s_ready drops until the result drains.
`default_nettype none
`include "assert_macros.svh"

module strict_priority_call_scheduler
    import spsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    in_item_t    item_reg;
    logic        item_vld_reg;
    out_item_t   out_reg;
    logic        m_valid_reg;

    logic        accept;
    logic        commit;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t      wr_data;
    entry_t      head_data;
    out_item_t   result;

    assign commit  = item_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !item_vld_reg || commit;
    assign accept  = s_valid && s_ready;

    spsc_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit    (commit),
        .item      (item_reg),
        .head_data (head_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .result    (result)
    );

    spsc_queue_mem #(
        .DEPTH(MEM_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (head_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                item_vld_reg <= 1'b1;
            end else if (commit) begin
                item_vld_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        if (commit) begin
            out_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // a decided item always lands in the output register
    `ASSERT_NEXT(a_commit_out, commit, m_valid_reg, "committed item produced no result")
    // a held item is never dropped while the output stalls
    `ASSERT_NEXT(a_hold_item, item_vld_reg && !commit, item_vld_reg, "stalled item lost")

endmodule

`default_nettype wire
